>>> rtl/core/afc_pkg.sv
// Shared types, constants and character helpers for the accession format checker.
package afc_pkg;

    localparam int LENGTH_LIMIT = 16;
    localparam int CNT_W        = $clog2(LENGTH_LIMIT + 1);
    localparam int CHAR_W       = 8;
    localparam int STATUS_W     = 3;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CHAR_W-1:0] char_t;

    typedef enum logic [2:0] {
        PH_ALPHA,
        PH_UNDER,
        PH_DIGIT,
        PH_VERSION,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        STOP_NONE,
        STOP_SPACE,
        STOP_DOT,
        STOP_OTHER
    } stop_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID,
        STATUS_NULL,
        STATUS_TOO_LONG,
        STATUS_NO_START_LETTERS,
        STATUS_WRONG_DIGITS,
        STATUS_MISSING_VERSION,
        STATUS_BAD_VERSION
    } status_t;

    // Body scanner state: letter, underscore, digit and version runs.
    typedef struct packed {
        phase_t     phase;
        cnt_t       alpha_count;
        logic [1:0] underscore_count;
        cnt_t       digit_count;
        cnt_t       version_digit_count;
        stop_t      stop_class;
        logic       version_bad_tail;
    } scan_t;

    // Whole per-string state.
    typedef struct packed {
        logic  ended;
        cnt_t  char_position;
        char_t head0;
        char_t head1;
        logic  all_blank;
        scan_t scan;
    } stream_t;

    function automatic logic is_upper(char_t c);
        return (c >= "A") && (c <= "Z");
    endfunction

    function automatic logic is_letter(char_t c);
        return is_upper(c) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_digit(char_t c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_blank(char_t c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic cnt_t sat_inc(cnt_t v);
        return (32'(v) < LENGTH_LIMIT) ? cnt_t'(v + 1'b1) : v;
    endfunction

    // Idle string state: nothing seen, blank so far, letter run pending.
    function automatic stream_t clear_stream();
        stream_t s;
        s                 = '0;
        s.all_blank       = 1'b1;
        s.scan.phase      = PH_ALPHA;
        s.scan.stop_class = STOP_NONE;
        return s;
    endfunction

    // One character through the run scanner; phases may fall through.
    function automatic scan_t scan_char(scan_t s, char_t c);
        scan_t r;
        logic  done;
        r    = s;
        done = 1'b0;
        if (r.phase == PH_ALPHA)
        begin
            if (is_letter(c))
            begin
                r.alpha_count = sat_inc(r.alpha_count);
                done = 1'b1;
            end
            else
            begin
                r.phase = PH_UNDER;
            end
        end
        if (!done && r.phase == PH_UNDER)
        begin
            if (c == "_")
            begin
                if (r.underscore_count != 2'd3)
                begin
                    r.underscore_count = r.underscore_count + 2'd1;
                end
                done = 1'b1;
            end
            else
            begin
                r.phase = PH_DIGIT;
            end
        end
        if (!done && r.phase == PH_DIGIT)
        begin
            if (is_digit(c))
            begin
                r.digit_count = sat_inc(r.digit_count);
            end
            else if (c == " ")
            begin
                r.stop_class = STOP_SPACE;
                r.phase      = PH_VERSION;
            end
            else if (c == ".")
            begin
                r.stop_class = STOP_DOT;
                r.phase      = PH_VERSION;
            end
            else
            begin
                r.stop_class = STOP_OTHER;
                r.phase      = PH_DONE;
            end
            done = 1'b1;
        end
        if (!done && r.phase == PH_VERSION)
        begin
            if (is_digit(c))
            begin
                r.version_digit_count = sat_inc(r.version_digit_count);
            end
            else
            begin
                if (c != " ")
                begin
                    r.version_bad_tail = 1'b1;
                end
                r.phase = PH_DONE;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/afc_scan.sv
// Per-string state registers and the one-character update.
module afc_scan
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  afc_pkg::char_t        char_code,
    input  logic                  last,
    output afc_pkg::stream_t      upd
);

    afc_pkg::stream_t st_reg;
    afc_pkg::stream_t st_next;

    // State after taking this character.
    always_comb
    begin
        upd = st_reg;
        if (!st_reg.ended)
        begin
            if (char_code == '0)
            begin
                upd.ended = 1'b1;
            end
            else
            begin
                if (!afc_pkg::is_blank(char_code))
                begin
                    upd.all_blank = 1'b0;
                end
                upd.char_position = afc_pkg::sat_inc(st_reg.char_position);
                if (st_reg.char_position == afc_pkg::cnt_t'(0))
                begin
                    upd.head0 = char_code;
                end
                else if (st_reg.char_position == afc_pkg::cnt_t'(1))
                begin
                    upd.head1 = char_code;
                end
                else if (st_reg.char_position == afc_pkg::cnt_t'(2))
                begin
                    // Skip the NZ_ prefix, else replay the held head characters.
                    if (!(st_reg.head0 == "N" && st_reg.head1 == "Z" && char_code == "_"))
                    begin
                        upd.scan = afc_pkg::scan_char(
                            afc_pkg::scan_char(
                                afc_pkg::scan_char(st_reg.scan, st_reg.head0),
                                st_reg.head1),
                            char_code);
                    end
                end
                else
                begin
                    upd.scan = afc_pkg::scan_char(st_reg.scan, char_code);
                end
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        if (step)
        begin
            st_next = last ? afc_pkg::clear_stream() : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= afc_pkg::clear_stream();
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

>>> rtl/core/afc_judge.sv
// Final status decision from the completed string state.
module afc_judge
(
    input  afc_pkg::stream_t st,
    input  logic             version_on,
    output afc_pkg::status_t status
);

    int   a;
    int   d;
    int   pos;
    logic table_plain;
    logic digits_under;
    logic prefix_under;
    afc_pkg::status_t ver;

    always_comb
    begin
        a   = 32'(st.scan.alpha_count);
        d   = 32'(st.scan.digit_count);
        pos = 32'(st.char_position);

        table_plain = (a == 1 && d == 5) || (a == 2 && d == 6) || (a == 3 && d == 5) ||
                      (a == 4 && d == 8) || (a == 5 && d == 7);
        digits_under = (a == 2) && (d == 6 || d == 8 || d == 9);
        prefix_under =
            ((st.head0 == "N" || st.head0 == "X" || st.head0 == "Z") &&
             (st.head1 == "M" || st.head1 == "C" || st.head1 == "T" || st.head1 == "P" ||
              st.head1 == "G" || st.head1 == "R" || st.head1 == "S" || st.head1 == "W" ||
              st.head1 == "Z")) ||
            ((st.head0 == "A" || st.head0 == "Y") && st.head1 == "P");

        // Version suffix outcome.
        ver = afc_pkg::STATUS_VALID;
        if (version_on)
        begin
            if (st.scan.stop_class == afc_pkg::STOP_NONE)
            begin
                ver = afc_pkg::STATUS_MISSING_VERSION;
            end
            else
            begin
                if (st.scan.stop_class != afc_pkg::STOP_DOT)
                begin
                    ver = afc_pkg::STATUS_MISSING_VERSION;
                end
                if (st.scan.version_digit_count == '0)
                begin
                    ver = afc_pkg::STATUS_MISSING_VERSION;
                end
                else if (st.scan.version_bad_tail)
                begin
                    ver = afc_pkg::STATUS_BAD_VERSION;
                end
            end
        end

        if (st.all_blank)
        begin
            status = afc_pkg::STATUS_NULL;
        end
        else if (pos >= afc_pkg::LENGTH_LIMIT)
        begin
            status = afc_pkg::STATUS_TOO_LONG;
        end
        else if (pos < 3 || !afc_pkg::is_upper(st.head0) ||
                 !afc_pkg::is_upper(st.head1))
        begin
            status = afc_pkg::STATUS_NO_START_LETTERS;
        end
        else if (st.scan.stop_class == afc_pkg::STOP_OTHER ||
                 st.scan.underscore_count > 2'd1)
        begin
            status = afc_pkg::STATUS_WRONG_DIGITS;
        end
        else if (st.scan.underscore_count == 2'd0)
        begin
            status = table_plain ? ver : afc_pkg::STATUS_WRONG_DIGITS;
        end
        else
        begin
            status = (digits_under && prefix_under) ? ver : afc_pkg::STATUS_WRONG_DIGITS;
        end
    end

endmodule

>>> rtl/core/accession_format_checker.sv
// Top level of the accession format checker: stream ports, input and result registers.
//
// Usage:
//   Feed an accession string one character per item on the s_ channel, with
//   s_tlast high on the final character. A character code of zero ends the
//   string early; later characters up to s_tlast are ignored. Exactly one
//   status item leaves on the m_ channel for every item that carries s_tlast.
//   cfg_data sets whether a version suffix is demanded; write it only while
//   the block is idle. cfg_ready is always high.
// Throughput:
//   One character per cycle while no last character is held back by a
//   waiting status. An accepted item is held in the input register while the
//   string state updates; a last character then loads its status into the
//   result register and raises m_tvalid.
// Reset:
//   rst_n clears the string state, both valid flags and the version setting.
// Stall:
//   While m_tready is low and a status waits, characters that are not the
//   last keep flowing; a last character waits in the input register and
//   s_tready drops until the result register frees.
module accession_format_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] status, [7:3] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // 1 demands a version suffix
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    afc_pkg::char_t       in_char_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    afc_pkg::status_t     status_reg;
    logic                 version_on_reg;
    logic                 advance;
    logic                 take_in;
    afc_pkg::stream_t     upd;
    afc_pkg::status_t     status;

    // Advance the held item unless it is a last one blocked by a waiting result.
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign take_in   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - afc_pkg::STATUS_W){1'b0}}, status_reg};

    afc_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (in_char_reg),
        .last      (in_last_reg),
        .upd       (upd)
    );

    afc_judge u_judge
    (
        .st         (upd),
        .version_on (version_on_reg),
        .status     (status)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            version_on_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                version_on_reg <= cfg_data;
            end
        end
    end

    // Payload registers, no reset: input on acceptance, status when a last character advances.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            status_reg <= status;
        end
    end

endmodule
